// ===== rtl/snti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snti_pkg
// Shared types, property bit masks and node kind codes for the node type
// inference block.
// ----------------------------------------------------------------------------
package snti_pkg;

    localparam int unsigned PROP_W = 14;
    localparam int unsigned CMD_W  = 5;

    typedef logic [PROP_W-1:0] t_props;
    typedef logic [CMD_W-1:0]  t_cmd;

    typedef struct packed {
        t_cmd   command;
        t_props x_props;
        t_props y_props;
        t_props z_props;
    } t_snti_req;

    typedef struct packed {
        t_props node_props;
        logic   unsupported;
        logic   rule_violation;
    } t_snti_rsp;

    // property bits
    localparam t_props P_K = 14'h0001;
    localparam t_props P_V = 14'h0002;
    localparam t_props P_B = 14'h0004;
    localparam t_props P_W = 14'h0008;
    localparam t_props P_Z = 14'h0010;
    localparam t_props P_O = 14'h0020;
    localparam t_props P_N = 14'h0040;
    localparam t_props P_D = 14'h0080;
    localparam t_props P_U = 14'h0100;
    localparam t_props P_E = 14'h0200;
    localparam t_props P_F = 14'h0400;
    localparam t_props P_S = 14'h0800;
    localparam t_props P_M = 14'h1000;
    localparam t_props P_X = 14'h2000;

    localparam t_props P_BASE = P_K | P_V | P_B | P_W;

    // node kinds
    localparam t_cmd CMD_PK        = 5'd0;
    localparam t_cmd CMD_PK_H      = 5'd1;
    localparam t_cmd CMD_OLDER     = 5'd2;
    localparam t_cmd CMD_AFTER     = 5'd3;
    localparam t_cmd CMD_SHA256    = 5'd4;
    localparam t_cmd CMD_RIPEMD160 = 5'd5;
    localparam t_cmd CMD_HASH256   = 5'd6;
    localparam t_cmd CMD_HASH160   = 5'd7;
    localparam t_cmd CMD_TRUE      = 5'd8;
    localparam t_cmd CMD_FALSE     = 5'd9;
    localparam t_cmd CMD_WRAP_A    = 5'd10;
    localparam t_cmd CMD_WRAP_S    = 5'd11;
    localparam t_cmd CMD_WRAP_C    = 5'd12;
    localparam t_cmd CMD_WRAP_D    = 5'd13;
    localparam t_cmd CMD_WRAP_V    = 5'd14;
    localparam t_cmd CMD_WRAP_J    = 5'd15;
    localparam t_cmd CMD_WRAP_N    = 5'd16;
    localparam t_cmd CMD_AND_V     = 5'd17;
    localparam t_cmd CMD_AND_B     = 5'd18;
    localparam t_cmd CMD_OR_B      = 5'd19;
    localparam t_cmd CMD_OR_D      = 5'd20;
    localparam t_cmd CMD_OR_C      = 5'd21;
    localparam t_cmd CMD_OR_I      = 5'd22;
    localparam t_cmd CMD_ANDOR     = 5'd23;
    localparam t_cmd CMD_THRESH_M  = 5'd24;

    function automatic logic f_has(input t_props m, input t_props req);
        return (m & req) == req;
    endfunction

    function automatic t_props f_when(input logic c, input t_props v);
        return c ? v : '0;
    endfunction

endpackage

// ===== rtl/snti_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snti_if
// Valid/ready channels carrying node requests and typed results.
// ----------------------------------------------------------------------------
interface snti_req_if import snti_pkg::*; ();
    logic      valid;
    logic      ready;
    t_snti_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface snti_rsp_if import snti_pkg::*; ();
    logic      valid;
    logic      ready;
    t_snti_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/snti_rules.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snti_rules
// Per-kind property rules, sanitisation and consistency check for one node.
// ----------------------------------------------------------------------------
module snti_rules import snti_pkg::*; (
    input  t_snti_req i_req,
    output t_snti_rsp o_rsp
);

    t_props x;
    t_props y;
    t_props z;
    t_props xy;
    t_props w;
    t_props raw;
    t_props base;
    logic   bad;
    logic   viol;

    assign x    = i_req.x_props;
    assign y    = i_req.y_props;
    assign z    = i_req.z_props;
    assign xy   = x | y;
    assign w    = x | (y & z);
    assign base = raw & P_BASE;

    always_comb begin
        bad = 1'b0;
        case (i_req.command)
            CMD_PK: begin
                raw = P_K|P_O|P_N|P_U|P_D|P_E|P_M|P_S|P_X;
            end
            CMD_PK_H: begin
                raw = P_K|P_N|P_U|P_D|P_E|P_M|P_S|P_X;
            end
            CMD_OLDER, CMD_AFTER: begin
                raw = P_B|P_Z|P_F|P_M|P_X;
            end
            CMD_SHA256, CMD_RIPEMD160, CMD_HASH256, CMD_HASH160: begin
                raw = P_B|P_O|P_N|P_U|P_D|P_M;
            end
            CMD_TRUE: begin
                raw = P_B|P_Z|P_U|P_F|P_M|P_X;
            end
            CMD_FALSE: begin
                raw = P_B|P_Z|P_U|P_D|P_E|P_M|P_S|P_X;
            end
            CMD_WRAP_A: begin
                raw = f_when(f_has(x, P_B), P_W) | (x & (P_U|P_D|P_F|P_E|P_M|P_S)) | P_X;
            end
            CMD_WRAP_S: begin
                raw = f_when(f_has(x, P_B|P_O), P_W)
                    | (x & (P_U|P_D|P_F|P_E|P_M|P_S|P_X));
            end
            CMD_WRAP_C: begin
                raw = f_when(f_has(x, P_K), P_B) | (x & (P_O|P_N|P_D|P_E|P_M)) | P_U | P_S;
            end
            CMD_WRAP_D: begin
                raw = f_when(f_has(x, P_V|P_Z), P_B) | f_when(f_has(x, P_Z), P_O)
                    | f_when(f_has(x, P_F), P_E) | (x & (P_M|P_S)) | P_N|P_U|P_D|P_X;
            end
            CMD_WRAP_V: begin
                raw = f_when(f_has(x, P_B), P_V) | (x & (P_Z|P_O|P_N|P_M|P_S)) | P_F|P_X;
            end
            CMD_WRAP_J: begin
                raw = f_when(f_has(x, P_B|P_N), P_B) | f_when(f_has(x, P_F), P_E)
                    | (x & (P_O|P_U|P_M|P_S)) | P_N|P_D|P_X;
            end
            CMD_WRAP_N: begin
                raw = (x & (P_B|P_Z|P_O|P_N|P_D|P_F|P_E|P_M|P_S)) | P_U|P_X;
            end
            CMD_AND_V: begin
                raw = f_when(f_has(x, P_V), y & (P_K|P_V|P_B)) | (x & P_N)
                    | f_when(f_has(x, P_Z), y & P_N) | f_when(f_has(xy, P_Z), xy & P_O)
                    | (x & y & (P_D|P_M|P_Z)) | (xy & P_S) | (y & (P_U|P_F|P_X));
            end
            CMD_AND_B: begin
                raw = f_when(f_has(y, P_W), x & P_B) | f_when(f_has(xy, P_Z), xy & P_O)
                    | (x & P_N) | f_when(f_has(x, P_Z), y & P_N)
                    | f_when(f_has(x & y, P_S), x & y & P_E)
                    | (x & y & (P_D|P_F|P_Z|P_M)) | (xy & P_S) | P_U|P_X;
            end
            CMD_OR_B: begin
                raw = f_when(f_has(x, P_B|P_D) && f_has(y, P_W|P_D), P_B)
                    | f_when(f_has(xy, P_Z), xy & P_O)
                    | f_when(f_has(xy, P_S) && f_has(x & y, P_E), x & y & P_M)
                    | (x & y & (P_Z|P_S|P_E)) | P_D|P_U|P_X;
            end
            CMD_OR_D: begin
                raw = f_when(f_has(x, P_B|P_D|P_U), y & P_B)
                    | f_when(f_has(y, P_Z), x & P_O)
                    | f_when(f_has(x, P_E) && f_has(xy, P_S), x & y & P_M)
                    | (x & y & (P_Z|P_E|P_S)) | (y & (P_U|P_F|P_D)) | P_X;
            end
            CMD_OR_C: begin
                raw = f_when(f_has(x, P_B|P_D|P_U), y & P_V)
                    | f_when(f_has(y, P_Z), x & P_O)
                    | f_when(f_has(x, P_E) && f_has(xy, P_S), x & y & P_M)
                    | (x & y & (P_Z|P_S)) | P_F|P_X;
            end
            CMD_OR_I: begin
                raw = (x & y & (P_V|P_B|P_K|P_U|P_F|P_S))
                    | f_when(f_has(x & y, P_Z), P_O) | f_when(f_has(xy, P_F), xy & P_E)
                    | f_when(f_has(xy, P_S), x & y & P_M) | (xy & P_D) | P_X;
            end
            CMD_ANDOR: begin
                raw = f_when(f_has(x, P_B|P_D|P_U), y & z & (P_B|P_K|P_V))
                    | (x & y & z & P_Z) | f_when(f_has(w, P_Z), w & P_O)
                    | (y & z & (P_F|P_U)) | (z & P_D)
                    | f_when(f_has(x, P_S) || f_has(y, P_F), x & z & P_E)
                    | f_when(f_has(x, P_E) && f_has(xy | z, P_S), x & y & z & P_M)
                    | (z & xy & P_S) | P_X;
            end
            CMD_THRESH_M: begin
                raw = P_B|P_N|P_U|P_D|P_E|P_M|P_S;
            end
            default: begin
                raw = '0;
                bad = 1'b1;
            end
        endcase
    end

    // exactly one base type, then the pairwise implications and conflicts
    always_comb begin
        viol = !((base != '0) && ((base & (base - 14'd1)) == '0))
            || f_has(raw, P_Z|P_O) || f_has(raw, P_N|P_Z) || f_has(raw, P_V|P_D)
            || (((raw & P_K) != '0) && ((raw & P_U) == '0))
            || f_has(raw, P_V|P_U) || f_has(raw, P_E|P_F)
            || (((raw & P_E) != '0) && ((raw & P_D) == '0))
            || f_has(raw, P_V|P_E) || f_has(raw, P_D|P_F)
            || (((raw & P_V) != '0) && ((raw & P_F) == '0))
            || (((raw & P_K) != '0) && ((raw & P_S) == '0))
            || (((raw & P_Z) != '0) && ((raw & P_M) == '0));
    end

    assign o_rsp.node_props     = (base == '0) ? '0 : raw;
    assign o_rsp.unsupported    = bad;
    assign o_rsp.rule_violation = (base != '0) && viol;

endmodule

// ===== rtl/script_node_type_inference.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_node_type_inference
// Path: input register, rule logic, result register; a result is valid once its
//   request has passed through both registers.
// Throughput: one node per cycle while the receiver is ready; stages advance
//   whenever the next one is free or being drained.
// Reset: synchronous active-low i_rst_n empties both stages.
// ----------------------------------------------------------------------------
module script_node_type_inference import snti_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    snti_req_if.sink      i_req,
    snti_rsp_if.source    o_rsp
);

    logic      r_in_valid;
    t_snti_req r_in_data;
    logic      r_out_valid;
    t_snti_rsp r_out_data;
    t_snti_rsp n_out_data;
    logic      out_free;
    logic      in_free;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign in_free  = !r_in_valid || out_free;

    snti_rules u_rules (
        .i_req (r_in_data),
        .o_rsp (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_req.valid) begin
            r_in_data <= i_req.data;
        end
        if (out_free && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign i_req.ready = in_free;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

endmodule

// ===== sim/script_node_type_inference_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_node_type_inference_test
// Self-checking bench for the node type inference block. Node requests are
// driven over the valid/ready request channel with random sender and receiver
// stalls. Every transfer is typed by an independent model of the typing rules
// and the expected results are compared field by field with each returned
// result. The run has a short directed set covering every node kind, then
// random requests built mostly from well-formed child types.
// ----------------------------------------------------------------------------
module script_node_type_inference_test;
    import snti_pkg::*;

    localparam t_cmd CMD_THRESH = 5'd25;
    localparam t_cmd CMD_TOP    = 5'd31;
    localparam int   STALL_LIMIT = 5000;
    localparam int   DRAIN_CYCLES = 10;
    localparam int   RANDOM_PER_PHASE = 650;

    class node_type_scoreboard;
        t_snti_rsp   pending_types[$];
        int          errors;
        int          checked;
        int          n_unsup;
        int          n_untyped;
        int          n_flagged;
        bit [31:0]   kinds_seen;

        function bit covers(t_props m, t_props req);
            return (m & req) == req;
        endfunction

        function bit inconsistent(t_props t);
            if ($countones(t & P_BASE) != 1) return 1'b1;
            if (covers(t, P_Z | P_O)) return 1'b1;
            if (covers(t, P_N | P_Z)) return 1'b1;
            if (covers(t, P_V | P_D)) return 1'b1;
            if ((t & P_K) != 0 && (t & P_U) == 0) return 1'b1;
            if (covers(t, P_V | P_U)) return 1'b1;
            if (covers(t, P_E | P_F)) return 1'b1;
            if ((t & P_E) != 0 && (t & P_D) == 0) return 1'b1;
            if (covers(t, P_V | P_E)) return 1'b1;
            if (covers(t, P_D | P_F)) return 1'b1;
            if ((t & P_V) != 0 && (t & P_F) == 0) return 1'b1;
            if ((t & P_K) != 0 && (t & P_S) == 0) return 1'b1;
            if ((t & P_Z) != 0 && (t & P_M) == 0) return 1'b1;
            return 1'b0;
        endfunction

        function t_snti_rsp type_node(t_cmd c, t_props x, t_props y, t_props z);
            t_snti_rsp res;
            t_props    xy;
            t_props    w;
            t_props    r;
            xy  = x | y;
            w   = x | (y & z);
            res = '0;
            case (c)
                CMD_PK: r = P_K | P_O | P_N | P_U | P_D | P_E | P_M | P_S | P_X;
                CMD_PK_H: r = P_K | P_N | P_U | P_D | P_E | P_M | P_S | P_X;
                CMD_OLDER, CMD_AFTER: r = P_B | P_Z | P_F | P_M | P_X;
                CMD_SHA256, CMD_RIPEMD160, CMD_HASH256, CMD_HASH160:
                    r = P_B | P_O | P_N | P_U | P_D | P_M;
                CMD_TRUE: r = P_B | P_Z | P_U | P_F | P_M | P_X;
                CMD_FALSE: r = P_B | P_Z | P_U | P_D | P_E | P_M | P_S | P_X;
                CMD_WRAP_A: r = (covers(x, P_B) ? P_W : '0)
                              | (x & (P_U | P_D | P_F | P_E | P_M | P_S)) | P_X;
                CMD_WRAP_S: r = (covers(x, P_B | P_O) ? P_W : '0)
                              | (x & (P_U | P_D | P_F | P_E | P_M | P_S | P_X));
                CMD_WRAP_C: r = (covers(x, P_K) ? P_B : '0)
                              | (x & (P_O | P_N | P_D | P_E | P_M)) | P_U | P_S;
                CMD_WRAP_D: r = (covers(x, P_V | P_Z) ? P_B : '0)
                              | (covers(x, P_Z) ? P_O : '0)
                              | (covers(x, P_F) ? P_E : '0)
                              | (x & (P_M | P_S)) | P_N | P_U | P_D | P_X;
                CMD_WRAP_V: r = (covers(x, P_B) ? P_V : '0)
                              | (x & (P_Z | P_O | P_N | P_M | P_S)) | P_F | P_X;
                CMD_WRAP_J: r = (covers(x, P_B | P_N) ? P_B : '0)
                              | (covers(x, P_F) ? P_E : '0)
                              | (x & (P_O | P_U | P_M | P_S)) | P_N | P_D | P_X;
                CMD_WRAP_N: r = (x & (P_B | P_Z | P_O | P_N | P_D | P_F | P_E | P_M | P_S))
                              | P_U | P_X;
                CMD_AND_V: r = (covers(x, P_V) ? (y & (P_K | P_V | P_B)) : '0)
                             | (x & P_N)
                             | (covers(x, P_Z) ? (y & P_N) : '0)
                             | (covers(xy, P_Z) ? (xy & P_O) : '0)
                             | (x & y & (P_D | P_M | P_Z)) | (xy & P_S)
                             | (y & (P_U | P_F | P_X));
                CMD_AND_B: r = (covers(y, P_W) ? (x & P_B) : '0)
                             | (covers(xy, P_Z) ? (xy & P_O) : '0)
                             | (x & P_N)
                             | (covers(x, P_Z) ? (y & P_N) : '0)
                             | (covers(x & y, P_S) ? (x & y & P_E) : '0)
                             | (x & y & (P_D | P_F | P_Z | P_M)) | (xy & P_S)
                             | P_U | P_X;
                CMD_OR_B: r = ((covers(x, P_B | P_D) && covers(y, P_W | P_D)) ? P_B : '0)
                            | (covers(xy, P_Z) ? (xy & P_O) : '0)
                            | ((covers(xy, P_S) && covers(x & y, P_E)) ? (x & y & P_M) : '0)
                            | (x & y & (P_Z | P_S | P_E)) | P_D | P_U | P_X;
                CMD_OR_D: r = (covers(x, P_B | P_D | P_U) ? (y & P_B) : '0)
                            | (covers(y, P_Z) ? (x & P_O) : '0)
                            | ((covers(x, P_E) && covers(xy, P_S)) ? (x & y & P_M) : '0)
                            | (x & y & (P_Z | P_E | P_S)) | (y & (P_U | P_F | P_D)) | P_X;
                CMD_OR_C: r = (covers(x, P_B | P_D | P_U) ? (y & P_V) : '0)
                            | (covers(y, P_Z) ? (x & P_O) : '0)
                            | ((covers(x, P_E) && covers(xy, P_S)) ? (x & y & P_M) : '0)
                            | (x & y & (P_Z | P_S)) | P_F | P_X;
                CMD_OR_I: r = (x & y & (P_V | P_B | P_K | P_U | P_F | P_S))
                            | (covers(x & y, P_Z) ? P_O : '0)
                            | (covers(xy, P_F) ? (xy & P_E) : '0)
                            | (covers(xy, P_S) ? (x & y & P_M) : '0)
                            | (xy & P_D) | P_X;
                CMD_ANDOR: r = (covers(x, P_B | P_D | P_U) ? (y & z & (P_B | P_K | P_V)) : '0)
                             | (x & y & z & P_Z)
                             | (covers(w, P_Z) ? (w & P_O) : '0)
                             | (y & z & (P_F | P_U)) | (z & P_D)
                             | ((covers(x, P_S) || covers(y, P_F)) ? (x & z & P_E) : '0)
                             | ((covers(x, P_E) && covers(xy | z, P_S))
                                ? (x & y & z & P_M) : '0)
                             | (z & xy & P_S) | P_X;
                CMD_THRESH_M: r = P_B | P_N | P_U | P_D | P_E | P_M | P_S;
                default: begin
                    r = '0;
                    res.unsupported = 1'b1;
                end
            endcase
            if ((r & P_BASE) == 0) begin
                res.node_props = '0;
            end else begin
                res.node_props     = r;
                res.rule_violation = inconsistent(r);
            end
            return res;
        endfunction

        function void note_request(t_snti_req q);
            t_snti_rsp e;
            e = type_node(q.command, q.x_props, q.y_props, q.z_props);
            kinds_seen[q.command] = 1'b1;
            if (e.unsupported) n_unsup++;
            else if (e.node_props == 0) n_untyped++;
            if (e.rule_violation) n_flagged++;
            pending_types.push_back(e);
        endfunction

        function void check_result(t_snti_rsp got);
            t_snti_rsp e;
            if (pending_types.size() == 0) begin
                $error("unexpected result: node_props %h unsupported %b rule_violation %b",
                       got.node_props, got.unsupported, got.rule_violation);
                errors++;
                return;
            end
            e = pending_types.pop_front();
            checked++;
            if (got.node_props !== e.node_props) begin
                $error("node_props: expected %h, got %h", e.node_props, got.node_props);
                errors++;
            end
            if (got.unsupported !== e.unsupported) begin
                $error("unsupported: expected %b, got %b", e.unsupported, got.unsupported);
                errors++;
            end
            if (got.rule_violation !== e.rule_violation) begin
                $error("rule_violation: expected %b, got %b",
                       e.rule_violation, got.rule_violation);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    snti_req_if req_ch ();
    snti_rsp_if rsp_ch ();

    script_node_type_inference dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    node_type_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles = 0;

    // typical well-formed child types
    t_props child_types [12] = '{
        P_K | P_O | P_N | P_U | P_D | P_E | P_M | P_S | P_X,
        P_K | P_N | P_U | P_D | P_E | P_M | P_S | P_X,
        P_B | P_Z | P_F | P_M | P_X,
        P_B | P_O | P_N | P_U | P_D | P_M,
        P_B | P_Z | P_U | P_F | P_M | P_X,
        P_B | P_Z | P_U | P_D | P_E | P_M | P_S | P_X,
        P_B | P_N | P_U | P_D | P_E | P_M | P_S,
        P_V | P_F | P_M | P_X,
        P_V | P_Z | P_F | P_M | P_S | P_X,
        P_W | P_D | P_U | P_E | P_M | P_S | P_X,
        P_W | P_U | P_F | P_M | P_X,
        P_B | P_O | P_U | P_D | P_E | P_M | P_S | P_X
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_node(t_snti_req q);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(q);
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending_types.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_props pick_child();
        t_props m;
        if ($urandom_range(99) < 30) return t_props'($urandom);
        m = child_types[$urandom_range(11)];
        if ($urandom_range(3) == 0) m ^= t_props'(1) << $urandom_range(PROP_W - 1);
        return m;
    endfunction

    task automatic run_directed();
        t_snti_req q;
        int        i;
        for (i = 0; i <= CMD_THRESH + 1; i++) begin
            q.command = (i > CMD_THRESH) ? CMD_TOP : t_cmd'(i);
            q.x_props = (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : child_types[i % 12];
            q.y_props = (i % 5 == 0) ? '1 : child_types[(i + 3) % 12];
            q.z_props = (i % 2 == 1) ? '0 : child_types[(i + 5) % 12];
            send_node(q);
        end
    endtask

    task automatic run_random(int count);
        t_snti_req q;
        repeat (count) begin
            if ($urandom_range(99) < 8)
                q.command = t_cmd'($urandom_range(CMD_TOP, CMD_THRESH + 1));
            else
                q.command = t_cmd'($urandom_range(CMD_THRESH));
            q.x_props = pick_child();
            q.y_props = pick_child();
            q.z_props = pick_child();
            send_node(q);
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        send_idle_pct = 17;
        recv_idle_pct = 79;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        hold_until_drained();
        run_random(RANDOM_PER_PHASE);

        send_idle_pct = 79;
        recv_idle_pct = 17;
        hold_until_drained();
        run_random(RANDOM_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_types.size() != 0) begin
            $error("%0d results never returned", sb.pending_types.size());
            sb.errors++;
        end

        $display("Typed %0d nodes over %0d of 32 kind codes under three stall profiles.",
                 sb.checked, $countones(sb.kinds_seen));
        $display("Seen: %0d unsupported, %0d without base type, %0d inconsistent.",
                 sb.n_unsup, sb.n_untyped, sb.n_flagged);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/snti_pkg.sv
rtl/snti_if.sv
rtl/snti_rules.sv
rtl/script_node_type_inference.sv
sim/script_node_type_inference_test.sv
